[src/hdlcdm_pkg.sv]
// Shared constants, types and the cell encoder for the HDLC transmitter.
// Used by hdlc_diff_manchester_transmitter and its testbench.
// No dependencies.
package hdlcdm_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [2:0] MAX_FLAGS = 3'd5;
    localparam logic [2:0] RUN_LIMIT = 3'd5;
    localparam logic [2:0] FLAGS_RESET = 3'd5;
    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef struct packed {
        logic stuffed_bit;
        logic half_only;
        logic level_second_half;
        logic level_first_half;
    } cell_t;

    // Differential Manchester: one holds the level mid-cell, zero toggles it.
    function automatic cell_t encode_cell(input logic level, input logic bit_val,
                                          input logic stuffed);
        cell_t c;
        c.level_first_half  = level;
        c.level_second_half = bit_val ? level : ~level;
        c.half_only         = 1'b0;
        c.stuffed_bit       = stuffed;
        return c;
    endfunction

endpackage

[src/hdlc_diff_manchester_transmitter.sv]
// HDLC frame transmitter with bit stuffing and differential Manchester coding.
// Depends on hdlcdm_pkg.
//
// Usage:
//   Input stream (s_*): one frame byte per transfer. s_tdata holds the byte,
//   s_tuser marks the first byte of a frame, s_tlast the last one.
//   Output stream (m_*): one bit cell per transfer, m_tlast on the final cell
//   that the input byte causes.
//   cfg_*: writes start_flag_count (3 bits); always ready, write only while idle.
// Timing:
//   One sequencer steps through flag, data, stuff, closing flag and final
//   cells, using a single cell encoder, one cell per cycle unless m_tready
//   stalls the output. The first cell is encoded after the input transfer has
//   set the state register and appears once it enters the output register.
//   A byte makes cells = 8 * flags + 8 + stuffed zeros + (last ? 9 : 0),
//   so 8 to 58 cells. s_tready is low while a byte is in work.
// Reset: line level goes to one, ones count to zero, flag count to five,
//   output empty.
// Stall: m_tready low holds the current cell and freezes the sequencer; a
//   new byte is taken once the last cell has entered the output register.
module hdlc_diff_manchester_transmitter (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] frame_byte
    input  logic       s_tuser,   // [0] first_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [0] level_first_half, [1] level_second_half,
                                  // [2] half_only, [3] stuffed_bit, [7:4] zero
    output logic       m_tlast,   // last_cell
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_data   // [2:0] start_flag_count
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FLAG  = 3'd1;
    localparam logic [2:0] ST_DATA  = 3'd2;
    localparam logic [2:0] ST_STUFF = 3'd3;
    localparam logic [2:0] ST_CLOSE = 3'd4;
    localparam logic [2:0] ST_FINAL = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [2:0] cfg_flags_reg, cfg_flags_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;
    logic [2:0] flag_cnt_reg, flag_cnt_next;
    logic [2:0] bit_idx_reg, bit_idx_next;
    logic       level_reg, level_next;
    logic [2:0] ones_reg, ones_next;
    logic       out_valid_reg, out_valid_next;
    hdlcdm_pkg::cell_t out_cell_reg, out_cell_next;
    logic       out_last_reg, out_last_next;

    logic       in_xfer;
    logic       out_free;
    logic       bit_val;
    logic       stuffed;
    logic [2:0] ones_inc;
    logic [2:0] flags_sat;
    hdlcdm_pkg::cell_t enc_cell;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign flags_sat = (cfg_flags_reg > hdlcdm_pkg::MAX_FLAGS) ?
                       hdlcdm_pkg::MAX_FLAGS : cfg_flags_reg;

    // Shared encoder input: pick the bit for the current sequencer step.
    always_comb
    begin
        bit_val = hdlcdm_pkg::FLAG_BYTE[bit_idx_reg];
        stuffed = 1'b0;
        if (state_reg == ST_DATA)
        begin
            bit_val = data_reg[bit_idx_reg];
        end
        else if (state_reg == ST_STUFF)
        begin
            bit_val = 1'b0;
            stuffed = 1'b1;
        end
    end

    assign enc_cell = hdlcdm_pkg::encode_cell(level_reg, bit_val, stuffed);
    assign ones_inc = bit_val ? (ones_reg + 3'd1) : 3'd0;

    always_comb
    begin
        state_next     = state_reg;
        cfg_flags_next = cfg_flags_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        flag_cnt_next  = flag_cnt_reg;
        bit_idx_next   = bit_idx_reg;
        level_next     = level_reg;
        ones_next      = ones_reg;
        out_valid_next = out_valid_reg;
        out_cell_next  = out_cell_reg;
        out_last_next  = out_last_reg;

        if (cfg_valid && cfg_ready)
        begin
            cfg_flags_next = cfg_data;
        end

        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (in_xfer)
        begin
            data_next    = s_tdata;
            last_next    = s_tlast;
            bit_idx_next = '0;
            state_next   = ST_DATA;
            if (s_tuser)
            begin
                level_next    = 1'b1;
                ones_next     = '0;
                flag_cnt_next = flags_sat;
                if (flags_sat != 3'd0)
                begin
                    state_next = ST_FLAG;
                end
            end
        end
        else if (state_reg != ST_IDLE && out_free)
        begin
            out_valid_next = 1'b1;
            out_cell_next  = enc_cell;
            out_last_next  = 1'b0;
            level_next     = ~enc_cell.level_second_half;
            bit_idx_next   = bit_idx_reg + 3'd1;
            unique case (state_reg)
                ST_FLAG:
                begin
                    if (bit_idx_reg == hdlcdm_pkg::LAST_BIT)
                    begin
                        flag_cnt_next = flag_cnt_reg - 3'd1;
                        if (flag_cnt_reg == 3'd1)
                        begin
                            state_next = ST_DATA;
                        end
                    end
                end
                ST_DATA:
                begin
                    ones_next = ones_inc;
                    if (ones_inc >= hdlcdm_pkg::RUN_LIMIT)
                    begin
                        state_next = ST_STUFF;
                    end
                    else if (bit_idx_reg == hdlcdm_pkg::LAST_BIT)
                    begin
                        state_next    = last_reg ? ST_CLOSE : ST_IDLE;
                        out_last_next = !last_reg;
                    end
                end
                ST_STUFF:
                begin
                    ones_next    = '0;
                    bit_idx_next = bit_idx_reg;
                    // index wrapped to zero: the stuffed zero followed bit 7
                    if (bit_idx_reg == 3'd0)
                    begin
                        state_next    = last_reg ? ST_CLOSE : ST_IDLE;
                        out_last_next = !last_reg;
                    end
                    else
                    begin
                        state_next = ST_DATA;
                    end
                end
                ST_CLOSE:
                begin
                    if (bit_idx_reg == hdlcdm_pkg::LAST_BIT)
                    begin
                        state_next = ST_FINAL;
                    end
                end
                ST_FINAL:
                begin
                    out_cell_next.level_second_half = 1'b0;
                    out_cell_next.half_only         = 1'b1;
                    out_cell_next.stuffed_bit       = 1'b0;
                    out_last_next                   = 1'b1;
                    level_next                      = level_reg;
                    bit_idx_next                    = bit_idx_reg;
                    state_next                      = ST_IDLE;
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cfg_flags_reg <= hdlcdm_pkg::FLAGS_RESET;
            flag_cnt_reg  <= '0;
            bit_idx_reg   <= '0;
            level_reg     <= 1'b1;
            ones_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cfg_flags_reg <= cfg_flags_next;
            flag_cnt_reg  <= flag_cnt_next;
            bit_idx_reg   <= bit_idx_next;
            level_reg     <= level_next;
            ones_reg      <= ones_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg     <= data_next;
        last_reg     <= last_next;
        out_cell_reg <= out_cell_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_cell_reg};
    assign m_tlast  = out_last_reg;

endmodule

[src/hdlcdm_chk.sv]
// Port-level checker for hdlc_diff_manchester_transmitter, with its bind.
// No package dependencies; sees the top-level ports only.
module hdlcdm_chk (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // hold a stalled cell
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output cell changed");

    // the final half cell always closes the item's transfers
    a_half_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> m_tlast && !m_tdata[1] && !m_tdata[3])
        else $error("half-only cell malformed");

    // a stuffed cell is a zero: level toggles mid-cell
    a_stuff_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> (m_tdata[0] != m_tdata[1]))
        else $error("stuffed cell is not a zero");

    // drop ready once a byte is taken: every byte makes at least eight cells
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // padding bits stay zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:4] == 4'b0000)
        else $error("output padding not zero");

endmodule

bind hdlc_diff_manchester_transmitter hdlcdm_chk u_hdlcdm_chk (.*);

[sim/tb_hdlc_diff_manchester_transmitter.sv]
// Self-checking testbench for hdlc_diff_manchester_transmitter: a directed table, then
// random frames, with every output cell compared against an in-bench line-coding model.
// Depends on hdlcdm_pkg and the transmitter RTL.
`timescale 1ns / 100ps

module tb_hdlc_diff_manchester_transmitter;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 16;
    localparam int PHASE_ITEMS    = 25;
    localparam int MAX_REPORTS    = 10;
    localparam logic [3:0] NO_CFG = 4'hF;

    typedef struct packed {
        logic              last_cell;
        hdlcdm_pkg::cell_t enc;
    } cell_rec_t;

    // One directed transfer: optional flag count write first, then the byte.
    // cells is the typed cell count for this byte, 0 when left to the model.
    typedef struct packed {
        logic [3:0] flags;
        logic [7:0] data;
        logic       first;
        logic       last;
        logic [5:0] cells;
    } dir_row_t;

    localparam int DIR_ROWS = 22;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tuser;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [2:0] cfg_data;

    // Line coder model state
    logic [2:0] flag_cfg = hdlcdm_pkg::FLAGS_RESET;
    logic       line_lvl = 1'b1;
    logic [2:0] ones_cnt = 3'd0;

    cell_rec_t  pending_cells[$];
    int         typed_counts[$];
    int         item_cells = 0;
    int         errors = 0;
    int         idle_cycles = 0;
    logic       hold_rx = 1'b0;
    logic       tx_calm = 1'b0;
    logic       rx_calm = 1'b0;

    dir_row_t   dir_table [0:DIR_ROWS-1];
    int unsigned phase_flags [0:7] = '{0, 7, 1, 5, 6, 2, 3, 4};

    always #2 clk = ~clk;

    hdlc_diff_manchester_transmitter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    function automatic void push_cell(input logic bit_val, input logic stuffed);
        cell_rec_t r;
        r = '0;
        r.enc.level_first_half  = line_lvl;
        r.enc.level_second_half = bit_val ? line_lvl : ~line_lvl;
        r.enc.stuffed_bit       = stuffed;
        // toggle at every cell boundary
        line_lvl = ~r.enc.level_second_half;
        pending_cells.push_back(r);
    endfunction

    function automatic void push_flag();
        for (int i = 0; i < 8; i++)
            push_cell(hdlcdm_pkg::FLAG_BYTE[i], 1'b0);
    endfunction

    function automatic void encode_byte_cells(input logic [7:0] d, input logic f,
                                              input logic l);
        logic [2:0] nflags;
        cell_rec_t  r;
        if (f)
        begin
            nflags   = (flag_cfg > hdlcdm_pkg::MAX_FLAGS) ? hdlcdm_pkg::MAX_FLAGS : flag_cfg;
            line_lvl = 1'b1;
            ones_cnt = 3'd0;
            for (int k = 0; k < nflags; k++)
                push_flag();
        end
        for (int i = 0; i < 8; i++)
        begin
            push_cell(d[i], 1'b0);
            ones_cnt = d[i] ? ones_cnt + 3'd1 : 3'd0;
            if (ones_cnt >= hdlcdm_pkg::RUN_LIMIT)
            begin
                push_cell(1'b0, 1'b1);
                ones_cnt = 3'd0;
            end
        end
        if (l)
        begin
            push_flag();
            r = '0;
            r.enc.level_first_half = line_lvl;
            r.enc.half_only        = 1'b1;
            pending_cells.push_back(r);
        end
        r = pending_cells.pop_back();
        r.last_cell = 1'b1;
        pending_cells.push_back(r);
    endfunction

    function automatic logic [7:0] rand_data();
        case ($urandom_range(0, 3))
            0: return 8'($urandom);
            1: return 8'hFF;
            2: return 8'($urandom | $urandom);
            default: return ~(8'h01 << $urandom_range(0, 7));
        endcase
    endfunction

    // Call at a falling edge; returns at a falling edge with s_tvalid still high.
    task automatic send_byte(input logic [7:0] d, input logic f, input logic l,
                             input int typed);
        int gap;
        if ($urandom_range(0, 19) == 0)
            tx_calm = ~tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= f;
        s_tlast  <= l;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        encode_byte_cells(d, f, l);
        typed_counts.push_back(typed);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_flag_count(input logic [2:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        flag_cfg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Output sink: random gaps per cell, one long hold-off on request
    initial
    begin
        int gap;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 19) == 0)
                rx_calm = ~rx_calm;
            gap = rx_calm ? 0 : $urandom_range(0, 3);
            if (hold_rx)
            begin
                gap     = RX_HOLD_CYCLES;
                hold_rx = 1'b0;
            end
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Cell checker
    always @(posedge clk)
    begin
        cell_rec_t want;
        int        typed;
        if (rst_n && m_tvalid && m_tready)
        begin
            item_cells++;
            if (pending_cells.size() == 0)
                note_error($sformatf("unexpected cell: data=%02h last=%0b", m_tdata, m_tlast));
            else
            begin
                want = pending_cells.pop_front();
                if (m_tdata[3:0] != want.enc || m_tdata[7:4] != 4'd0
                    || m_tlast != want.last_cell)
                    note_error($sformatf({"cell mismatch: expected first=%0b second=%0b ",
                        "half=%0b stuffed=%0b last=%0b, got data=%02h last=%0b"},
                        want.enc.level_first_half, want.enc.level_second_half,
                        want.enc.half_only, want.enc.stuffed_bit, want.last_cell,
                        m_tdata, m_tlast));
            end
            if (m_tlast)
            begin
                if (typed_counts.size() != 0)
                begin
                    typed = typed_counts.pop_front();
                    if (typed != 0 && typed != item_cells)
                        note_error($sformatf("cell count mismatch: expected %0d, got %0d",
                            typed, item_cells));
                end
                item_cells = 0;
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int sent;
        int flen;
        logic paused;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'd0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 3'd0;
        paused    = 1'b0;

        dir_table = '{
            '{NO_CFG, 8'h00, 1'b1, 1'b1, 6'd57},
            '{NO_CFG, 8'hFF, 1'b1, 1'b1, 6'd58},
            '{NO_CFG, 8'h00, 1'b0, 1'b0, 6'd8},
            '{NO_CFG, 8'h1F, 1'b1, 1'b0, 6'd49},
            '{NO_CFG, 8'h80, 1'b0, 1'b0, 6'd0},
            '{NO_CFG, 8'hFF, 1'b0, 1'b0, 6'd0},
            '{NO_CFG, 8'hFF, 1'b0, 1'b0, 6'd0},
            '{NO_CFG, 8'h7E, 1'b0, 1'b1, 6'd0},
            '{NO_CFG, 8'h55, 1'b0, 1'b1, 6'd0},
            '{NO_CFG, 8'hAA, 1'b0, 1'b0, 6'd0},
            '{4'd0,   8'h00, 1'b1, 1'b1, 6'd17},
            '{NO_CFG, 8'hFF, 1'b1, 1'b0, 6'd9},
            '{NO_CFG, 8'hF8, 1'b0, 1'b1, 6'd0},
            '{4'd1,   8'h00, 1'b1, 1'b0, 6'd16},
            '{NO_CFG, 8'h3E, 1'b0, 1'b0, 6'd0},
            '{NO_CFG, 8'h01, 1'b0, 1'b1, 6'd0},
            '{4'd7,   8'h00, 1'b1, 1'b1, 6'd57},
            '{4'd6,   8'h00, 1'b1, 1'b0, 6'd48},
            '{NO_CFG, 8'hFF, 1'b0, 1'b1, 6'd0},
            '{4'd5,   8'hC3, 1'b1, 1'b1, 6'd0},
            '{NO_CFG, 8'h0F, 1'b0, 1'b0, 6'd0},
            '{NO_CFG, 8'hF0, 1'b0, 1'b1, 6'd0}
        };

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            if (dir_table[r].flags != NO_CFG)
                write_flag_count(dir_table[r].flags[2:0]);
            send_byte(dir_table[r].data, dir_table[r].first, dir_table[r].last,
                      int'(dir_table[r].cells));
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            write_flag_count(3'(phase_flags[ph]));
            sent = 0;
            // stall the sink long enough to back up the input
            if (ph == 2)
                hold_rx = 1'b1;
            while (sent < PHASE_ITEMS)
            begin
                if (ph == 5 && sent >= PHASE_ITEMS / 2 && !paused)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                if ($urandom_range(0, 6) == 0)
                begin
                    send_byte(rand_data(), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 0);
                    sent++;
                end
                else
                begin
                    flen = $urandom_range(1, 6);
                    for (int k = 0; k < flen; k++)
                        send_byte(rand_data(), k == 0, k == flen - 1, 0);
                    sent += flen;
                end
            end
        end

        wait_drained();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
